// ----- rtl/core/rkp_pkg.sv -----
`timescale 1ns / 1ps

package rkp_pkg;

  localparam int WORD_BITS    = 64;
  localparam int MAX_WORDS    = 4;
  localparam int MAX_KMER_LEN = 128;
  localparam int PORT_CAP     = MAX_WORDS * WORD_BITS / 2;
  localparam int KMER_CAP     = (MAX_KMER_LEN < PORT_CAP) ? MAX_KMER_LEN : PORT_CAP;

  localparam int LEN_W   = 8;
  localparam int IDX_W   = $clog2(MAX_WORDS);
  localparam int POS_W   = $clog2(WORD_BITS);
  localparam int TOT_W   = LEN_W + 1;
  localparam int LBITS_W = POS_W + 1;
  localparam int FIFO_DEPTH = 2;

  localparam logic [LEN_W-1:0] KMER_RESET = LEN_W'(32);

  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } code_xfer_t;

  typedef struct packed {
    logic [LEN_W-1:0]     k;
    logic [IDX_W-1:0]     nwords_m1;
    logic [POS_W-1:0]     last_pos;
    logic [WORD_BITS-1:0] last_mask;
  } kmer_cfg_t;

  function automatic kmer_cfg_t derive_cfg(logic [LEN_W-1:0] len);
    kmer_cfg_t          c;
    logic [LEN_W-1:0]   k;
    logic [TOT_W-1:0]   total;
    logic [TOT_W-1:0]   total_m1;
    logic [IDX_W-1:0]   nwm1;
    logic [TOT_W-1:0]   lbits_w;
    logic [LBITS_W-1:0] lbits;
    k = (len == '0) ? LEN_W'(1) : len;
    if (k > LEN_W'(KMER_CAP)) k = LEN_W'(KMER_CAP);
    total    = {k, 1'b0};
    total_m1 = total - TOT_W'(1);
    nwm1     = IDX_W'(total_m1 >> POS_W);
    lbits_w  = total - (TOT_W'(nwm1) << POS_W);
    lbits    = LBITS_W'(lbits_w);
    c.k         = k;
    c.nwords_m1 = nwm1;
    c.last_pos  = POS_W'(lbits - LBITS_W'(2));
    c.last_mask = (lbits >= LBITS_W'(WORD_BITS)) ? '1
                  : ((WORD_BITS'(1) << lbits) - WORD_BITS'(1));
    return c;
  endfunction

endpackage

// ----- rtl/core/rkp_front.sv -----
`timescale 1ns / 1ps

module rkp_front (
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // base_char
  input  logic                q_full,
  output rkp_pkg::code_xfer_t push
);
  import rkp_pkg::*;

  logic [1:0] code;

  always_comb begin
    case (s_tdata)
      CHAR_C:  code = CODE_C;
      CHAR_G:  code = CODE_G;
      CHAR_T:  code = CODE_T;
      default: code = CODE_A;
    endcase
  end

  // hold off the producer while reset is applied
  assign s_tready   = !q_full && !rst;
  assign push.valid = s_tvalid && s_tready;
  assign push.code  = code;

endmodule

// ----- rtl/core/rkp_code_fifo.sv -----
`timescale 1ns / 1ps

module rkp_code_fifo (
  input  logic                clk,
  input  logic                rst,
  input  rkp_pkg::code_xfer_t push,
  output logic                full,
  output rkp_pkg::code_xfer_t head,
  input  logic                pop
);
  import rkp_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [1:0]       mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full      = (count == CNT_W'(FIFO_DEPTH));
  assign head.valid = (count != '0);
  assign head.code  = mem[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_ptr] <= push.code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)     rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push.valid, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/rkp_back.sv -----
`timescale 1ns / 1ps

module rkp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  rkp_pkg::kmer_cfg_t         cfg,
  input  rkp_pkg::code_xfer_t        head,
  output logic                       pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [rkp_pkg::WORD_BITS-1:0] m_tdata,
  output logic [rkp_pkg::IDX_W-1:0]  m_tuser,
  output logic                       m_tlast
);
  import rkp_pkg::*;

  logic [WORD_BITS-1:0] window      [MAX_WORDS];
  logic [WORD_BITS-1:0] window_next [MAX_WORDS];
  logic [LEN_W-1:0]     bases_seen;
  logic [LEN_W-1:0]     seen_next;
  logic                 emitting;
  logic [IDX_W-1:0]     idx;
  logic                 load;
  logic                 last_now;

  assign last_now = (idx == cfg.nwords_m1);
  assign load     = emitting && (!m_tvalid || m_tready);
  // the next base may shift in on the same edge the final word is loaded
  assign pop      = head.valid && (!emitting || (load && last_now));
  assign seen_next = (bases_seen < cfg.k) ? bases_seen + LEN_W'(1) : bases_seen;

  always_comb begin
    for (int i = 0; i < MAX_WORDS; i++) begin
      window_next[i] = window[i];
      if (IDX_W'(i) == cfg.nwords_m1) begin
        window_next[i] = {window[i][WORD_BITS-3:0], head.code} & cfg.last_mask;
      end
    end
    for (int i = 0; i < MAX_WORDS - 1; i++) begin
      if (IDX_W'(i) < cfg.nwords_m1) begin
        // carry the top two bits of the following word
        if (IDX_W'(i + 1) == cfg.nwords_m1)
          window_next[i] = {window[i][WORD_BITS-3:0], window[i+1][cfg.last_pos +: 2]};
        else
          window_next[i] = {window[i][WORD_BITS-3:0], window[i+1][WORD_BITS-1 -: 2]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      for (int i = 0; i < MAX_WORDS; i++) window[i] <= '0;
    end else if (pop) begin
      for (int i = 0; i < MAX_WORDS; i++) window[i] <= window_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      bases_seen <= '0;
      emitting   <= 1'b0;
      idx        <= '0;
    end else begin
      if (pop) bases_seen <= seen_next;
      // a fresh k-mer takes over from the one whose final word is loading
      if (pop && seen_next >= cfg.k) begin
        emitting <= 1'b1;
        idx      <= '0;
      end else if (load) begin
        idx <= idx + IDX_W'(1);
        if (last_now) emitting <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= window[idx];
      m_tuser <= idx;
      m_tlast <= last_now;
    end
  end

endmodule

// ----- rtl/core/rolling_kmer_2bit_packer.sv -----
`timescale 1ns / 1ps
// the first word of a k-mer is registered at the output after its base passes the code queue and the window
// each base from the k-th on yields ceil(2k/64) words (1 to 4) on the single 64-bit result port
// a two-entry code queue lets input transactions continue while words drain
// reset (synchronous, active high) clears window, base count, queue and output; k returns to 32
// a length write also clears window and base count

module rolling_kmer_2bit_packer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // base_char
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rkp_pkg::WORD_BITS-1:0] m_tdata,   // word_value
  output logic [rkp_pkg::IDX_W-1:0]     m_tuser,   // word_index
  output logic                          m_tlast,   // last_word
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rkp_pkg::LEN_W-1:0]     cfg_data   // bases in the window
);
  import rkp_pkg::*;

  code_xfer_t push;
  code_xfer_t head;
  kmer_cfg_t  cfg;
  logic       q_full;
  logic       pop;
  logic       cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= derive_cfg(KMER_RESET);
    end else if (cfg_write) begin
      cfg <= derive_cfg(cfg_data);
    end
  end

  rkp_front u_front (
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push)
  );

  rkp_code_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  rkp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- rtl/core/rkp_checker.sv -----
`timescale 1ns / 1ps

module rkp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rkp_pkg::WORD_BITS-1:0] m_tdata,
  input logic [rkp_pkg::IDX_W-1:0]     m_tuser,
  input logic                          m_tlast
);
  import rkp_pkg::*;

  logic [IDX_W-1:0] exp_idx;

  // expected word position within the current k-mer
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (m_tvalid && m_tready) begin
      exp_idx <= m_tlast ? '0 : exp_idx + IDX_W'(1);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result changed while stalled");

  a_index_seq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == exp_idx)
    else $error("word index out of sequence");

  a_top_word_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == IDX_W'(MAX_WORDS - 1) |-> m_tlast)
    else $error("final word position not flagged last");

  a_reset_quiet: assert property (@(posedge clk)
    rst |-> !s_tready ##1 !m_tvalid)
    else $error("activity during or right after reset");

endmodule

bind rolling_kmer_2bit_packer rkp_checker u_rkp_checker (.*);
